FILE: rtl/link_keepalive_session_fsm_top_assert.svh
// Assertion macros for the session block's top level.
// Needs nothing else; define ASSERT_OFF to compile the checks away.
`ifndef LINK_KEEPALIVE_SESSION_FSM_TOP_ASSERT_SVH
`define LINK_KEEPALIVE_SESSION_FSM_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define LKS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("session check failed");
`define LKS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("session check failed");
`else
`define LKS_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define LKS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

FILE: rtl/lks_pkg.sv
// Types, codes and helpers for the keepalive session block.
// No dependencies; imported by lks_step and the top level.
package lks_pkg;

    typedef enum logic [3:0] {
        ST_IDLE      = 4'b0001,
        ST_PENDING   = 4'b0010,
        ST_CONNECTED = 4'b0100,
        ST_CLOSING   = 4'b1000
    } state_t;

    localparam logic [2:0] CMD_CONNECT    = 3'd0;
    localparam logic [2:0] CMD_DISCONNECT = 3'd1;
    localparam logic [2:0] CMD_TICK       = 3'd2;
    localparam logic [2:0] CMD_DROP       = 3'd3;
    localparam logic [2:0] CMD_ACCEPT     = 3'd4;
    localparam logic [2:0] CMD_ALIVE      = 3'd5;

    localparam logic [2:0] MSG_NONE       = 3'd0;
    localparam logic [2:0] MSG_CONNECT    = 3'd1;
    localparam logic [2:0] MSG_DISCONNECT = 3'd2;
    localparam logic [2:0] MSG_ALIVE      = 3'd3;
    localparam logic [2:0] MSG_GET_STATE  = 3'd4;

    localparam logic [1:0] NOTE_NONE         = 2'd0;
    localparam logic [1:0] NOTE_CONNECTING   = 2'd1;
    localparam logic [1:0] NOTE_ACCEPTED     = 2'd2;
    localparam logic [1:0] NOTE_DISCONNECTED = 2'd3;

    localparam logic [1:0] CAUSE_LOCAL   = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [1:0] CAUSE_DROP    = 2'd2;

    localparam logic [1:0] CODE_IDLE      = 2'd0;
    localparam logic [1:0] CODE_PENDING   = 2'd1;
    localparam logic [1:0] CODE_CONNECTED = 2'd2;
    localparam logic [1:0] CODE_CLOSING   = 2'd3;

    localparam logic [1:0] CFG_IDX_SEND_INTERVAL = 2'd0;
    localparam logic [1:0] CFG_IDX_TIMEOUT       = 2'd1;

    localparam logic [15:0] SEND_INTERVAL_RST = 16'd1000;
    localparam logic [15:0] TIMEOUT_RST       = 16'd60000;

    typedef struct packed {
        logic [2:0] sent_message;
        logic [1:0] notice;
        logic [1:0] disconnect_cause;
        logic [1:0] session_state;
    } result_t;

    function automatic logic [1:0] state_code(input state_t st);
        logic [1:0] code;
        unique case (st)
            ST_IDLE:      code = CODE_IDLE;
            ST_PENDING:   code = CODE_PENDING;
            ST_CONNECTED: code = CODE_CONNECTED;
            ST_CLOSING:   code = CODE_CLOSING;
            default:      code = CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

FILE: rtl/lks_step.sv
// Next-state and result logic for one session event.
// Depends on lks_pkg; pure combinational, instanced by the top level.
module lks_step
    import lks_pkg::*;
#(
    parameter int TIMER_WIDTH = 18,
    parameter int ID_WIDTH    = 16
) (
    input  logic [2:0]             command,
    input  logic [15:0]            elapsed_ms,
    input  logic [15:0]            offered_id,
    input  logic [15:0]            send_interval,
    input  logic [15:0]            alive_timeout,
    input  state_t                 link_cur,
    input  logic [TIMER_WIDTH-1:0] send_timer_cur,
    input  logic [TIMER_WIDTH-1:0] recv_timer_cur,
    input  logic                   skip_cur,
    input  logic [ID_WIDTH-1:0]    client_id_cur,
    output state_t                 link_nxt,
    output logic [TIMER_WIDTH-1:0] send_timer_nxt,
    output logic [TIMER_WIDTH-1:0] recv_timer_nxt,
    output logic                   skip_nxt,
    output logic [ID_WIDTH-1:0]    client_id_nxt,
    output result_t                result
);

    logic [TIMER_WIDTH:0]   send_sum;
    logic [TIMER_WIDTH:0]   recv_sum;
    logic [TIMER_WIDTH-1:0] send_sat;
    logic [TIMER_WIDTH-1:0] recv_sat;

    assign send_sum = {1'b0, send_timer_cur} + (TIMER_WIDTH+1)'(elapsed_ms);
    assign recv_sum = {1'b0, recv_timer_cur} + (TIMER_WIDTH+1)'(elapsed_ms);
    assign send_sat = send_sum[TIMER_WIDTH] ? '1 : send_sum[TIMER_WIDTH-1:0];
    assign recv_sat = recv_sum[TIMER_WIDTH] ? '1 : recv_sum[TIMER_WIDTH-1:0];

    always_comb begin
        link_nxt                = link_cur;
        send_timer_nxt          = send_timer_cur;
        recv_timer_nxt          = recv_timer_cur;
        skip_nxt                = skip_cur;
        client_id_nxt           = client_id_cur;
        result.sent_message     = MSG_NONE;
        result.notice           = NOTE_NONE;
        result.disconnect_cause = CAUSE_LOCAL;

        unique case (command)
            CMD_CONNECT: begin
                if (link_cur == ST_IDLE) begin
                    result.notice       = NOTE_CONNECTING;
                    result.sent_message = MSG_CONNECT;
                    send_timer_nxt      = '0;
                    recv_timer_nxt      = '0;
                    skip_nxt            = 1'b1;
                    link_nxt            = ST_PENDING;
                end
            end
            CMD_DISCONNECT: begin
                if (link_cur != ST_IDLE) begin
                    result.sent_message = MSG_DISCONNECT;
                    result.notice       = NOTE_DISCONNECTED;
                    link_nxt            = ST_IDLE;
                end
            end
            CMD_TICK: begin
                if (link_cur != ST_IDLE) begin
                    if (!skip_cur) begin
                        send_timer_nxt = send_sat;
                        recv_timer_nxt = recv_sat;
                    end else begin
                        skip_nxt = 1'b0;
                    end
                    if (send_timer_nxt > TIMER_WIDTH'(send_interval)) begin
                        result.sent_message = MSG_ALIVE;
                        send_timer_nxt      = '0;
                    end
                    if (recv_timer_nxt > TIMER_WIDTH'(alive_timeout)) begin
                        result.notice           = NOTE_DISCONNECTED;
                        result.disconnect_cause = CAUSE_TIMEOUT;
                        link_nxt                = ST_IDLE;
                    end
                    if (link_nxt == ST_CLOSING) begin
                        result.notice           = NOTE_DISCONNECTED;
                        result.disconnect_cause = CAUSE_DROP;
                        link_nxt                = ST_IDLE;
                    end
                end
            end
            CMD_DROP: begin
                if (link_cur != ST_IDLE) begin
                    link_nxt = ST_CLOSING;
                end
            end
            CMD_ACCEPT: begin
                if (link_cur == ST_PENDING) begin
                    client_id_nxt       = ID_WIDTH'(offered_id);
                    result.sent_message = MSG_GET_STATE;
                    result.notice       = NOTE_ACCEPTED;
                    link_nxt            = ST_CONNECTED;
                end
            end
            CMD_ALIVE: begin
                recv_timer_nxt = '0;
            end
            default: begin
            end
        endcase

        result.session_state = state_code(link_nxt);
    end

endmodule

FILE: rtl/link_keepalive_session_fsm_top.sv
// Top level of the keepalive session block: state, config and result registers.
// Depends on lks_pkg, lks_step and link_keepalive_session_fsm_top_assert.svh.
//
//  channel | direction | handshake           | payload
//  s_      | in        | s_valid / s_ready   | command, elapsed_ms, offered_id
//  m_      | out       | m_valid / m_ready   | sent_message, notice, cause, state, id
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle when m_ready allows; each result is registered and appears
// in the cycle after its item is accepted. The session state and timers update
// in the accept cycle, so the next item sees them at once. The result register
// stalls only on m_ready; s_ready is high while it is empty or being drained.
// Synchronous active-low reset clears state, timers, id and config to defaults.
`include "link_keepalive_session_fsm_top_assert.svh"

module link_keepalive_session_fsm_top
    import lks_pkg::*;
#(
    parameter int TIMER_WIDTH = 18,
    parameter int ID_WIDTH    = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [15:0] s_elapsed_ms,
    input  logic [15:0] s_offered_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_sent_message,
    output logic [1:0]  m_notice,
    output logic [1:0]  m_disconnect_cause,
    output logic [1:0]  m_session_state,
    output logic [15:0] m_assigned_id,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    state_t                 link_reg;
    state_t                 link_next;
    logic [TIMER_WIDTH-1:0] send_timer_reg;
    logic [TIMER_WIDTH-1:0] send_timer_next;
    logic [TIMER_WIDTH-1:0] recv_timer_reg;
    logic [TIMER_WIDTH-1:0] recv_timer_next;
    logic                   skip_reg;
    logic                   skip_next;
    logic [ID_WIDTH-1:0]    client_id_reg;
    logic [ID_WIDTH-1:0]    client_id_next;
    logic [15:0]            interval_reg;
    logic [15:0]            timeout_reg;
    logic                   m_valid_reg;
    result_t                result_reg;
    result_t                result_next;
    logic [15:0]            id_out_reg;
    logic                   s_fire;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    lks_step #(
        .TIMER_WIDTH(TIMER_WIDTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_step (
        .command       (s_command),
        .elapsed_ms    (s_elapsed_ms),
        .offered_id    (s_offered_id),
        .send_interval (interval_reg),
        .alive_timeout (timeout_reg),
        .link_cur      (link_reg),
        .send_timer_cur(send_timer_reg),
        .recv_timer_cur(recv_timer_reg),
        .skip_cur      (skip_reg),
        .client_id_cur (client_id_reg),
        .link_nxt      (link_next),
        .send_timer_nxt(send_timer_next),
        .recv_timer_nxt(recv_timer_next),
        .skip_nxt      (skip_next),
        .client_id_nxt (client_id_next),
        .result        (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg       <= ST_IDLE;
            send_timer_reg <= '0;
            recv_timer_reg <= '0;
            skip_reg       <= 1'b0;
            client_id_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_fire) begin
                link_reg       <= link_next;
                send_timer_reg <= send_timer_next;
                recv_timer_reg <= recv_timer_next;
                skip_reg       <= skip_next;
                client_id_reg  <= client_id_next;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            interval_reg <= SEND_INTERVAL_RST;
            timeout_reg  <= TIMEOUT_RST;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_IDX_SEND_INTERVAL) begin
                interval_reg <= cfg_data;
            end else if (cfg_index == CFG_IDX_TIMEOUT) begin
                timeout_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            result_reg <= result_next;
            id_out_reg <= 16'(client_id_next);
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_sent_message     = result_reg.sent_message;
    assign m_notice           = result_reg.notice;
    assign m_disconnect_cause = result_reg.disconnect_cause;
    assign m_session_state    = result_reg.session_state;
    assign m_assigned_id      = id_out_reg;

    `LKS_ASSERT_IMPLY(a_state_matches, aclk, aresetn, m_valid_reg,
        m_session_state == state_code(link_reg))
    `LKS_ASSERT_IMPLY(a_cause_only_on_disc, aclk, aresetn,
        m_valid_reg && (m_notice != NOTE_DISCONNECTED), m_disconnect_cause == CAUSE_LOCAL)
    `LKS_ASSERT_IMPLY(a_disc_goes_idle, aclk, aresetn,
        m_valid_reg && (m_notice == NOTE_DISCONNECTED), link_reg == ST_IDLE)
    `LKS_ASSERT_NEXT(a_alive_clears_recv, aclk, aresetn,
        s_fire && (s_command == CMD_ALIVE), recv_timer_reg == '0)

endmodule
